// ----- sv/afr_pkg.sv -----
package afr_pkg;

  localparam int unsigned FILL_WORDS        = 6;
  localparam int unsigned SMALL_FRAME_WORDS = 264;
  localparam int unsigned LARGE_FRAME_WORDS = 520;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned SMALL_W = $clog2(SMALL_FRAME_WORDS);
  localparam int unsigned LARGE_W = $clog2(LARGE_FRAME_WORDS);
  localparam int unsigned FILL_W  = (FILL_WORDS > 1) ? $clog2(FILL_WORDS) : 1;

  localparam logic [WORD_W-1:0] FILL_VALUE = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd3;

  typedef enum logic [1:0] {
    SRC_CODE,
    SRC_NUM,
    SRC_FILL,
    SRC_SAMPLE
  } src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_NUM,
    ST_FILL,
    ST_SAMPLE
  } step_t;

  localparam step_t NUM_NEXT = (FILL_WORDS == 0) ? ST_SAMPLE : ST_FILL;

  typedef struct packed {
    logic  dispatch;
    logic  emit;
    src_t  src;
    logic  hdr;
    logic  rpt;
    step_t nxt;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic fire;
    src_t src;
    logic hdr;
    logic last;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic boundary;
    logic out_ready;
    logic near_end;
  } stat_t;

  function automatic ucode_t uc_rom(step_t s);
    ucode_t u;
    u = '{dispatch: 1'b0, emit: 1'b0, src: SRC_SAMPLE, hdr: 1'b0, rpt: 1'b0, nxt: ST_IDLE};
    unique case (s)
      ST_IDLE:   begin
        u.dispatch = 1'b1;
      end
      ST_CODE:   begin
        u.emit = 1'b1; u.src = SRC_CODE; u.hdr = 1'b1; u.nxt = ST_NUM;
      end
      ST_NUM:    begin
        u.emit = 1'b1; u.src = SRC_NUM; u.hdr = 1'b1; u.nxt = NUM_NEXT;
      end
      ST_FILL:   begin
        u.emit = 1'b1; u.src = SRC_FILL; u.hdr = 1'b1; u.rpt = 1'b1; u.nxt = ST_SAMPLE;
      end
      ST_SAMPLE: begin
        u.emit = 1'b1; u.src = SRC_SAMPLE; u.nxt = ST_IDLE;
      end
      default:   begin
        u.dispatch = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

// ----- sv/afr_seq.sv -----
module afr_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  afr_pkg::stat_t stat,
  output afr_pkg::ctrl_t ctrl
);
  import afr_pkg::*;

  step_t              step;
  step_t              step_next;
  ucode_t             uc;
  logic [FILL_W-1:0]  fill_cnt;
  logic [FILL_W-1:0]  fill_cnt_next;
  logic               fill_done;

  assign uc        = uc_rom(step);
  assign fill_done = (fill_cnt == FILL_W'(FILL_WORDS - 1));

  // next step
  always_comb begin
    step_next     = step;
    fill_cnt_next = fill_cnt;
    if (uc.dispatch) begin
      fill_cnt_next = '0;
      if (in_valid && stat.go) begin
        step_next = stat.boundary ? ST_CODE : ST_SAMPLE;
      end
    end else if (ctrl.fire) begin
      if (ctrl.last) begin
        step_next = ST_IDLE;
      end else if (uc.rpt && !fill_done) begin
        fill_cnt_next = fill_cnt + FILL_W'(1);
      end else begin
        step_next = uc.nxt;
      end
    end
  end

  // control outputs
  always_comb begin
    ctrl.accept = uc.dispatch && in_valid;
    ctrl.fire   = uc.emit && stat.out_ready;
    ctrl.src    = uc.src;
    ctrl.hdr    = uc.hdr;
    ctrl.last   = (uc.src == SRC_SAMPLE) || stat.near_end;
    ctrl.idle   = uc.dispatch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= ST_IDLE;
      fill_cnt <= '0;
    end else begin
      step     <= step_next;
      fill_cnt <= fill_cnt_next;
    end
  end

endmodule

// ----- sv/afr_dp.sv -----
module afr_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [afr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [afr_pkg::WORD_W-1:0]           cfg_data,
  input  logic [afr_pkg::WORD_W-1:0]           sample,
  input  logic                                 capture_start,
  input  afr_pkg::ctrl_t                       ctrl,
  output afr_pkg::stat_t                       stat,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [afr_pkg::WORD_W-1:0]           out_word,
  output logic                                 is_header,
  output logic [afr_pkg::WORD_W-1:0]           word_pos,
  output logic [afr_pkg::FRAME_W-1:0]          frame_index,
  output logic                                 last
);
  import afr_pkg::*;

  logic [CODE_W-1:0]  channel_code;
  logic               large_frames;
  logic [WORD_W-1:0]  sample_limit;
  logic [WORD_W-1:0]  out_capacity;

  logic [WORD_W-1:0]  out_position;
  logic [FRAME_W-1:0] frame_count;
  logic [WORD_W-1:0]  samples_taken;
  logic [SMALL_W-1:0] mod_small;
  logic [LARGE_W-1:0] mod_large;
  logic [WORD_W-1:0]  sample_q;

  logic [WORD_W-1:0]  eff_pos;
  logic [FRAME_W-1:0] eff_frames;
  logic [WORD_W-1:0]  eff_taken;
  logic [SMALL_W-1:0] eff_small;
  logic [LARGE_W-1:0] eff_large;
  logic [FRAME_W-1:0] cur_frame;
  logic [WORD_W-1:0]  word_sel;

  // state as seen after an optional capture restart
  always_comb begin
    eff_pos    = capture_start ? '0 : out_position;
    eff_frames = capture_start ? '0 : frame_count;
    eff_taken  = capture_start ? '0 : samples_taken;
    eff_small  = capture_start ? '0 : mod_small;
    eff_large  = capture_start ? '0 : mod_large;
  end

  always_comb begin
    stat.go        = (eff_taken < sample_limit) && (eff_pos < out_capacity);
    stat.boundary  = large_frames ? (eff_large == '0) : (eff_small == '0);
    stat.out_ready = !out_valid || !out_stall;
    stat.near_end  = ((out_position + WORD_W'(1)) == out_capacity);
  end

  assign cur_frame = frame_count - FRAME_W'(1);

  always_comb begin
    case (ctrl.src)
      SRC_CODE:   word_sel = {{(WORD_W-CODE_W){1'b0}}, channel_code};
      SRC_NUM:    word_sel = {{(WORD_W-FRAME_W){1'b0}}, cur_frame};
      SRC_FILL:   word_sel = FILL_VALUE;
      SRC_SAMPLE: word_sel = sample_q;
      default:    word_sel = sample_q;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_code <= '0;
      large_frames <= 1'b0;
      sample_limit <= '0;
      out_capacity <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL:  channel_code <= cfg_data[CODE_W-1:0];
        CFG_LARGE:    large_frames <= cfg_data[0];
        CFG_LIMIT:    sample_limit <= cfg_data;
        CFG_CAPACITY: out_capacity <= cfg_data;
        default:      ;
      endcase
    end
  end

  // position and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      out_position  <= '0;
      frame_count   <= '0;
      samples_taken <= '0;
      mod_small     <= '0;
      mod_large     <= '0;
    end else if (ctrl.accept) begin
      out_position  <= eff_pos;
      mod_small     <= eff_small;
      mod_large     <= eff_large;
      frame_count   <= eff_frames + FRAME_W'(stat.go && stat.boundary);
      samples_taken <= eff_taken + WORD_W'(stat.go);
    end else if (ctrl.fire) begin
      out_position <= out_position + WORD_W'(1);
      mod_small    <= (mod_small == SMALL_W'(SMALL_FRAME_WORDS - 1)) ? '0
                    : mod_small + SMALL_W'(1);
      mod_large    <= (mod_large == LARGE_W'(LARGE_FRAME_WORDS - 1)) ? '0
                    : mod_large + LARGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      sample_q <= sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      out_word    <= word_sel;
      is_header   <= ctrl.hdr;
      word_pos    <= out_position;
      frame_index <= cur_frame;
      last        <= ctrl.last;
    end
  end

endmodule

// ----- sv/adc_sample_framer.sv -----
// channel  handshake             payload
// in       in_valid / in_stall   sample, capture_start
// out      out_valid / out_stall out_word, is_header, word_pos, frame_index, last
// cfg      cfg_we                cfg_index, cfg_data
//
// a sample is taken in the dispatch step, then the sequencer emits one word per cycle
// a sample without a header passes dispatch and sample, one that opens a frame
// passes dispatch, 8 header words, sample; output stalls hold the emit step
// in_stall is high whenever the sequencer is away from its dispatch step
// reset clears position/frame/sample counters and config, capacity to all ones
module adc_sample_framer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afr_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [afr_pkg::WORD_W-1:0]    sample,
  input  logic                          capture_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [afr_pkg::WORD_W-1:0]    out_word,
  output logic                          is_header,
  output logic [afr_pkg::WORD_W-1:0]    word_pos,
  output logic [afr_pkg::FRAME_W-1:0]   frame_index,
  output logic                          last
);
  import afr_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign in_stall = !ctrl.idle;

  afr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  afr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .capture_start (capture_start),
    .ctrl          (ctrl),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .is_header     (is_header),
    .word_pos      (word_pos),
    .frame_index   (frame_index),
    .last          (last)
  );

  a_fire_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire |-> stat.out_ready)
    else $error("word emitted while output register occupied");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.fire && ctrl.last) |=> ctrl.idle)
    else $error("sequencer busy after final word");

  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire |=> (out_valid && last == $past(ctrl.last)))
    else $error("emitted word not presented");

endmodule

// ----- sim/afr_stream_checker.sv -----
`timescale 1ns / 1ps

module afr_stream_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afr_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [afr_pkg::WORD_W-1:0]    sample,
  input  logic                          capture_start,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [afr_pkg::WORD_W-1:0]    out_word,
  input  logic                          is_header,
  input  logic [afr_pkg::WORD_W-1:0]    word_pos,
  input  logic [afr_pkg::FRAME_W-1:0]   frame_index,
  input  logic                          last,
  output int                            fails,
  output int                            pending
);
  import afr_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               header;
    logic [WORD_W-1:0]  pos;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } framer_word_t;

  logic [CODE_W-1:0]  chan_code;
  logic               large_sel;
  logic [WORD_W-1:0]  limit;
  logic [WORD_W-1:0]  capacity;
  logic [WORD_W-1:0]  pos_q;
  logic [FRAME_W-1:0] frame_q;
  logic [WORD_W-1:0]  taken_q;
  framer_word_t       expected_words[$];

  task automatic report(string msg);
    if (fails < 100) $display("%0t: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic bit put_word(logic [WORD_W-1:0] w, logic hdr, logic [FRAME_W-1:0] fr);
    framer_word_t e;
    if (pos_q >= capacity) return 1'b0;
    e.word   = w;
    e.header = hdr;
    e.pos    = pos_q;
    e.frame  = fr;
    e.last   = 1'b0;
    expected_words.push_back(e);
    pos_q = pos_q + 1'b1;
    return 1'b1;
  endfunction

  function automatic void pack_sample(logic [WORD_W-1:0] value, logic start);
    int unsigned        span_words;
    int                 first_new;
    bit                 ok;
    logic [FRAME_W-1:0] num;
    framer_word_t       tail;
    first_new = expected_words.size();
    ok = 1'b1;
    if (start) begin
      pos_q   = '0;
      frame_q = '0;
      taken_q = '0;
    end
    if (taken_q >= limit || pos_q >= capacity) return;
    taken_q = taken_q + 1'b1;
    span_words = large_sel ? LARGE_FRAME_WORDS : SMALL_FRAME_WORDS;
    if (pos_q % span_words == 0) begin
      num = frame_q;
      frame_q = frame_q + 1'b1;
      ok = put_word({{(WORD_W-CODE_W){1'b0}}, chan_code}, 1'b1, num);
      if (ok) ok = put_word({{(WORD_W-FRAME_W){1'b0}}, num}, 1'b1, num);
      for (int i = 0; ok && i < FILL_WORDS; i++) ok = put_word(FILL_VALUE, 1'b1, num);
    end
    if (ok) void'(put_word(value, 1'b0, frame_q - 1'b1));
    if (expected_words.size() > first_new) begin
      tail = expected_words[expected_words.size()-1];
      tail.last = 1'b1;
      expected_words[expected_words.size()-1] = tail;
    end
  endfunction

  always @(posedge clk) begin : watch
    framer_word_t want;
    if (rst) begin
      chan_code = '0;
      large_sel = 1'b0;
      limit     = '0;
      capacity  = '1;
      pos_q     = '0;
      frame_q   = '0;
      taken_q   = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL:  chan_code = cfg_data[CODE_W-1:0];
          CFG_LARGE:    large_sel = cfg_data[0];
          CFG_LIMIT:    limit     = cfg_data;
          CFG_CAPACITY: capacity  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pack_sample(sample, capture_start);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          // output transaction with nothing queued
          report($sformatf("unexpected word %0h at position %0d", out_word, word_pos));
        end else begin
          want = expected_words.pop_front();
          check_field("out_word", out_word, want.word);
          check_field("is_header", is_header, want.header);
          check_field("word_pos", word_pos, want.pos);
          check_field("frame_index", frame_index, want.frame);
          check_field("last", last, want.last);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ----- sim/adc_sample_framer_tb.sv -----
`timescale 1ns / 1ps

module adc_sample_framer_tb;
  import afr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_RUN = 65;
  localparam int LONG_RUN = 4 * PHASE_RUN;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [WORD_W-1:0]    sample = '0;
  logic                 capture_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_word;
  logic                 is_header;
  logic [WORD_W-1:0]    word_pos;
  logic [FRAME_W-1:0]   frame_index;
  logic                 last;

  logic rx_hold = 1'b0;
  logic pressure_on = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;
  int   fails;
  int   pending;

  adc_sample_framer DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .capture_start(capture_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .is_header(is_header), .word_pos(word_pos),
    .frame_index(frame_index), .last(last)
  );

  afr_stream_checker frame_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .capture_start(capture_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .is_header(is_header), .word_pos(word_pos),
    .frame_index(frame_index), .last(last),
    .fails(fails), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99, 0) < stall_pct);
  end

  initial begin
    wait (pressure_on);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_sample(logic [WORD_W-1:0] value, logic start);
    in_valid      <= 1'b1;
    sample        <= value;
    capture_start <= start;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [CODE_W-1:0] chan, logic big_frames,
                             logic [WORD_W-1:0] lim, logic [WORD_W-1:0] cap);
    settle();
    put_reg(CFG_CHANNEL, {{(WORD_W-CODE_W){1'b0}}, chan});
    put_reg(CFG_LARGE, {{(WORD_W-1){1'b0}}, big_frames});
    put_reg(CFG_LIMIT, lim);
    put_reg(CFG_CAPACITY, cap);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // sample limit still zero from reset
    send_sample(16'h1234, 1'b1);
    send_sample(16'h4321, 1'b0);

    reconfigure(3'd4, 1'b0, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0001, 1'b1);

    // capacity runs out inside the header
    reconfigure(3'd7, 1'b1, 16'd3, 16'd3);
    send_sample(16'h1111, 1'b1);
    send_sample(16'h2222, 1'b0);

    reconfigure(3'd5, 1'b0, 16'd2, 16'd9);
    send_sample(16'h3333, 1'b1);
    send_sample(16'h4444, 1'b0);
    send_sample(16'h5555, 1'b1);

    reconfigure(3'd6, 1'b1, 16'd2, 16'd8);
    send_sample(16'h6666, 1'b1);
    send_sample(16'h7777, 1'b0);

    reconfigure(3'd1, 1'b0, 16'd2, 16'd0);
    send_sample(16'h9999, 1'b1);

    reconfigure(3'd2, 1'b0, 16'd1, 16'hFFFF);
    send_sample(16'hABCD, 1'b1);
    send_sample(16'hDCBA, 1'b0);

    // one capture across a frame boundary, receiver held off at first
    reconfigure(3'd2, 1'b0, 16'hFFFF, 16'hFFFF);
    pressure_on <= 1'b1;
    for (int i = 0; i < LONG_RUN; i++) begin
      if (i == PHASE_RUN) begin
        send_idle_pct <= 61;
      end else if (i == 2 * PHASE_RUN) begin
        send_idle_pct <= 0;
        stall_pct <= 61;
      end else if (i == 3 * PHASE_RUN) begin
        send_idle_pct <= 7;
        stall_pct <= 7;
      end
      send_sample(16'($urandom_range(16'hFFFF, 0)), (i == 0));
    end

    settle();
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
